// File: rtl/swk_pkg.sv
package swk_pkg;

    localparam int CMD_VX      = 0;
    localparam int CMD_VY      = 1;
    localparam int CMD_OMEGA   = 2;
    localparam int CMD_COMPUTE = 15;

    localparam logic [7:0] PREV_HIGH_RST = 8'h05;
    localparam logic [7:0] PREV_LOW_RST  = 8'hdc;

    localparam int REG_SPEED_SCALE  = 0;
    localparam int REG_SPEED_OFFSET = 1;
    localparam int REG_FRONT_BASE   = 2;
    localparam int REG_REAR_BASE    = 3;
    localparam int REG_HALF_TRACK   = 4;

    localparam int CORDIC_MAX = 24;
    localparam int CW         = 44;

    typedef struct packed {
        logic [3:0] cmd;
        logic [3:0] sign_code;
        logic [7:0] magnitude;
    } t_in;

    typedef struct packed {
        logic [2:0]         wheel;
        logic signed [15:0] motor_drive;
        logic [10:0]        steer_drive;
        logic               last;
    } t_out;

    typedef struct packed {
        logic signed [8:0] vx;
        logic signed [8:0] vy;
        logic signed [8:0] om;
    } t_job;

    function automatic logic [16:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0: atan_q16 = 17'd51472;
            5'd1: atan_q16 = 17'd30386;
            5'd2: atan_q16 = 17'd16055;
            5'd3: atan_q16 = 17'd8150;
            5'd4: atan_q16 = 17'd4091;
            5'd5: atan_q16 = 17'd2047;
            5'd6: atan_q16 = 17'd1024;
            5'd7: atan_q16 = 17'd512;
            5'd8: atan_q16 = 17'd256;
            5'd9: atan_q16 = 17'd128;
            5'd10: atan_q16 = 17'd64;
            5'd11: atan_q16 = 17'd32;
            5'd12: atan_q16 = 17'd16;
            5'd13: atan_q16 = 17'd8;
            5'd14: atan_q16 = 17'd4;
            5'd15: atan_q16 = 17'd2;
            5'd16: atan_q16 = 17'd1;
            default: atan_q16 = 17'd0;
        endcase
    endfunction

endpackage

// File: rtl/swk_front.sv
module swk_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  swk_pkg::t_in  i_in,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output swk_pkg::t_job o_job
);
    import swk_pkg::*;

    logic [7:0]        r_high, r_low;
    logic signed [8:0] r_vx, r_vy, r_om;
    logic              r_ready;
    logic              r_qv;
    t_job              r_q;

    logic [7:0]        high;
    logic              diff, fire;
    logic signed [8:0] v;
    logic              take;

    assign full        = r_qv;
    assign o_job_valid = r_qv;
    assign o_job       = r_q;
    assign take        = push && !full;
    assign high        = {i_in.cmd, i_in.sign_code};
    assign diff        = (high != r_high) || (i_in.magnitude != r_low);
    assign v = (i_in.sign_code == 4'd1) ? -$signed({1'b0, i_in.magnitude})
                                        : $signed({1'b0, i_in.magnitude});
    // ready flag after this word, compute when command is 15
    always_comb begin
        fire = 1'b0;
        if (diff) begin
            fire = (i_in.cmd == 4'(CMD_COMPUTE)) && r_ready;
        end else begin
            fire = (r_high[7:4] == 4'(CMD_COMPUTE)) && r_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high  <= PREV_HIGH_RST;
            r_low   <= PREV_LOW_RST;
            r_vx    <= '0;
            r_vy    <= '0;
            r_om    <= '0;
            r_ready <= 1'b0;
            r_qv    <= 1'b0;
        end else begin
            if (r_qv && i_job_ready) begin
                r_qv <= 1'b0;
            end
            if (take) begin
                if (diff) begin
                    r_high <= high;
                    r_low  <= i_in.magnitude;
                    if (i_in.cmd != 4'(CMD_COMPUTE)) begin
                        if (i_in.cmd == 4'(CMD_VX)) r_vx <= v;
                        if (i_in.cmd == 4'(CMD_VY)) r_vy <= v;
                        if (i_in.cmd == 4'(CMD_OMEGA)) r_om <= v;
                        r_ready <= 1'b1;
                    end
                end
                if (fire) begin
                    r_ready <= 1'b0;
                    r_qv    <= 1'b1;
                    r_q.vx  <= r_vx;
                    r_q.vy  <= r_vy;
                    r_q.om  <= r_om;
                end
            end
        end
    end
endmodule

// File: rtl/swk_back.sv
module swk_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  swk_pkg::t_job i_job,
    input  logic [15:0]   i_scale,
    input  logic signed [15:0] i_offset,
    input  logic [10:0]   i_front,
    input  logic [10:0]   i_rear,
    input  logic [10:0]   i_track,
    output logic          empty,
    input  logic          pop,
    output swk_pkg::t_out o_res
);
    import swk_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < CORDIC_MAX) ? CORDIC_STEPS : CORDIC_MAX;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_W    = 3'd1;
    localparam logic [2:0] S_IT   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         r_st;
    t_job               r_job;
    logic [2:0]         r_k;
    logic [4:0]         r_i;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [23:0] r_z;
    logic signed [21:0] r_wx, r_wy;
    logic signed [CW+16:0] r_spd;
    logic signed [CW+34:0] r_m;
    logic signed [45:0] r_sn;
    logic signed [45:0] r_s;
    logic               r_ov;
    t_out               r_o;

    logic signed [12:0] rx, ry;
    logic signed [21:0] wx, wy, awx;
    logic signed [CW-1:0] xs, ys;
    logic signed [CW+34:0] mn, mr;
    logic signed [45:0] sn, sr;
    logic [45:0]        sa;
    logic [19:0]        sq;
    logic signed [16:0] mot;
    logic signed [12:0] st;

    always_comb begin
        case (r_k)
            3'd0, 3'd5: rx = $signed({2'b0, i_front});
            3'd1, 3'd4: rx = '0;
            default:    rx = -$signed({2'b0, i_rear});
        endcase
        ry = (r_k < 3'd3) ? $signed({2'b0, i_track}) : -$signed({2'b0, i_track});
        wx = 22'(r_job.vx * 256) + 22'(ry * r_job.om);
        wy = 22'(r_job.vy * 256) - 22'(rx * r_job.om);
        awx = (wx < 0) ? -wx : wx;
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        mn = $signed(r_spd[31:0]) * $signed({1'b0, i_scale}) + (79'(i_offset) <<< 24);
        mr = (mn >= 0) ? ((mn + (79'sd1 <<< 23)) >>> 24)
                       : -((-mn + (79'sd1 <<< 23)) >>> 24);
        // numerator stays positive for any angle; /6553600 as >>16, then /100 by x671089 >>26
        sn = 46'sd1507 * 46'sd6553600 - 46'(r_z) * 46'sd25093;
        sa = $unsigned(r_sn + 46'sd3276800) >> 16;
        sq = 20'((40'(sa[19:0]) * 40'd671089) >> 26);
        sr = 46'(sq);
        if (r_m > 79'sd32767) mot = 17'sd32767;
        else if (r_m < -79'sd32768) mot = -17'sd32768;
        else mot = 17'(r_m);
        if (r_wx > 22'sd2 || r_wx < -22'sd2) begin
            if (r_s < 0) st = '0;
            else if (r_s > 46'sd2047) st = 13'sd2047;
            else st = 13'(r_s);
        end else if (r_wy < 0) st = 13'sd1901;
        else st = 13'sd1113;
    end

    assign o_job_ready = (r_st == S_IDLE);
    assign empty       = !r_ov;
    assign o_res       = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && pop && r_st != S_OUT) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_k   <= '0;
                    r_st  <= S_W;
                end
                S_W: begin
                    r_wx <= wx;
                    r_wy <= wy;
                    r_x  <= CW'(awx) <<< 8;
                    r_y  <= (wx < 0) ? -(CW'(wy) <<< 8) : (CW'(wy) <<< 8);
                    r_z  <= '0;
                    r_i  <= '0;
                    r_st <= S_IT;
                end
                S_IT: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + ys; r_y <= r_y - xs;
                        r_z <= r_z + 24'(atan_q16(r_i));
                    end else begin
                        r_x <= r_x - ys; r_y <= r_y + xs;
                        r_z <= r_z - 24'(atan_q16(r_i));
                    end
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(NSTEP - 1)) r_st <= S_MUL;
                end
                S_MUL: begin
                    r_spd <= (r_x * 61'sd39797) >>> 16;
                    r_sn  <= sn;
                    r_st  <= S_FIN;
                end
                S_FIN: begin
                    r_m  <= mr;
                    r_s  <= sr;
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_ov || pop) begin
                    r_ov <= 1'b1;
                    r_o.wheel       <= r_k;
                    r_o.motor_drive <= 16'(mot);
                    r_o.steer_drive <= 11'(st);
                    r_o.last        <= (r_k == 3'd5);
                    r_k  <= r_k + 3'd1;
                    r_st <= (r_k == 3'd5) ? S_IDLE : S_W;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/six_wheel_swerve_kinematics.sv
// Compute request: job slot, then per wheel states S_W, S_IT, S_MUL, S_FIN and S_OUT.
// Each wheel runs through the shared CORDIC loop in turn: six wheels per compute.
// Other requests are taken when not full; a one-entry job slot decouples front and back.
// Synchronous active-low reset restores control state, config and command history.
module six_wheel_swerve_kinematics #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  swk_pkg::t_in  i_in,
    output logic          empty,
    input  logic          pop,
    output swk_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);
    import swk_pkg::*;

    logic [15:0]        r_scale;
    logic signed [15:0] r_offset;
    logic [10:0]        r_front, r_rear, r_track;
    logic               jv, jr;
    t_job               job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 16'd256;
            r_offset <= '0;
            r_front  <= 11'd256;
            r_rear   <= 11'd256;
            r_track  <= 11'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                3'(REG_SPEED_SCALE):  r_scale  <= i_cfg_data;
                3'(REG_SPEED_OFFSET): r_offset <= $signed(i_cfg_data);
                3'(REG_FRONT_BASE):   r_front  <= i_cfg_data[10:0];
                3'(REG_REAR_BASE):    r_rear   <= i_cfg_data[10:0];
                3'(REG_HALF_TRACK):   r_track  <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    swk_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_in,
        .o_job_valid(jv), .i_job_ready(jr), .o_job(job)
    );

    swk_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(jv), .o_job_ready(jr), .i_job(job),
        .i_scale(r_scale), .i_offset(r_offset), .i_front(r_front),
        .i_rear(r_rear), .i_track(r_track), .empty, .pop, .o_res(o_out)
    );
endmodule
